// ===== rtl/hmq_pkg.sv =====
// hmq_pkg: shared types and constants for the binary min-heap queue.
// Holds the request/result beat structs, heap entry type and FSM codes.
// No dependencies.
package hmq_pkg;

  localparam int CAPACITY  = 256;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 16;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // One request beat
  typedef struct packed {
    logic                 req_type;
    logic [ID_BITS-1:0]   item_id;
    logic [PRIO_BITS-1:0] item_priority;
    logic                 item_known;
  } req_t;

  // One result beat
  typedef struct packed {
    logic               accepted;
    logic [ID_BITS-1:0] popped_id;
    logic               top_valid;
    logic [ID_BITS-1:0] top_id;
    logic [CNT_W-1:0]   entry_count;
    logic               is_empty;
  } res_t;

  // Heap slot contents
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  // Compare unit mode
  typedef enum logic {
    CMP_UP,
    CMP_DN
  } cmp_mode_e;

  // Compare unit decision
  typedef struct packed {
    logic move;    // entry moves past the held one
    logic pick_b;  // sift-down: right child wins
  } cmp_res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/binary_min_heap_queue.sv =====
// binary_min_heap_queue: min-heap priority queue, one request at a time.
// A refused request (push when full or not known, pop when empty) goes straight to the result state;
// a push climbs from the new slot, moving each strictly larger parent down, and writes at its stop;
// a pop returns the root id and, unless it empties the heap, sifts the last entry down from the root.
// A new request is taken only in idle, after the result; busy covers accept to result.
// Reset clears the entry count, so the queue starts empty; results cannot stall.
module binary_min_heap_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  hmq_pkg::req_t  req_i,
  output logic           done_o,
  output hmq_pkg::res_t  res_o
);
  import hmq_pkg::*;

  state_e               state_q, state_d;
  entry_t               cur_q, cur_d;
  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ID_BITS-1:0]   root_q;
  logic                 acc_q, acc_d;
  logic [ID_BITS-1:0]   popped_q, popped_d;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  entry_t               wdata;
  logic [ADDR_W-1:0]    raddr_a;
  logic [ADDR_W-1:0]    raddr_b;
  entry_t               rdata_a;
  entry_t               rdata_b;

  cmp_mode_e            cmp_mode;
  logic                 vld_a;
  logic                 vld_b;
  cmp_res_t             cmp_res;

  logic [ADDR_W-1:0]    parent;
  logic [ADDR_W+1:0]    left_w;
  logic [ADDR_W+1:0]    right_w;
  logic [ADDR_W+1:0]    count_w;
  logic [CNT_W-1:0]     last;
  logic                 can_push;

  // heap index arithmetic
  assign parent   = (pos_q - ADDR_W'(1)) >> 1;
  assign left_w   = {1'b0, pos_q, 1'b1};
  assign right_w  = left_w + (ADDR_W+2)'(1);
  assign count_w  = (ADDR_W+2)'(count_q);
  assign last     = count_q - CNT_W'(1);
  assign can_push = (count_q < CNT_W'(CAPACITY)) && req_i.item_known;
  assign vld_a    = left_w < count_w;
  assign vld_b    = right_w < count_w;
  assign cmp_mode = (state_q == ST_UP_CMP) ? CMP_UP : CMP_DN;

  hmq_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  hmq_cmp u_cmp (
    .mode_i     (cmp_mode),
    .cur_prio_i (cur_q.prio),
    .ent_a_i    (rdata_a),
    .vld_a_i    (vld_a),
    .ent_b_i    (rdata_b),
    .vld_b_i    (vld_b),
    .res_o      (cmp_res)
  );

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      pos_q    <= '0;
      acc_q    <= 1'b0;
      popped_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      popped_q <= popped_d;
    end
  end

  // held entry and root id copy (payload)
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (we && (waddr == '0)) begin
      root_q <= wdata.id;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    pos_d    = pos_q;
    count_d  = count_q;
    acc_d    = acc_q;
    popped_d = popped_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = cur_q;
    raddr_a  = '0;
    raddr_b  = '0;

    unique case (state_q)
      ST_IDLE: begin
        // prefetch the last entry for a pop
        raddr_a = last[ADDR_W-1:0];
        if (start) begin
          acc_d    = 1'b0;
          popped_d = '0;
          state_d  = ST_DONE;
          if (req_i.req_type == REQ_PUSH) begin
            if (can_push) begin
              cur_d   = '{id: req_i.item_id, prio: req_i.item_priority};
              pos_d   = count_q[ADDR_W-1:0];
              acc_d   = 1'b1;
              state_d = ST_UP_RD;
            end
          end else if (count_q != '0) begin
            popped_d = root_q;
            acc_d    = 1'b1;
            state_d  = ST_POP_LD;
          end
        end
      end

      ST_UP_RD: begin
        raddr_a = parent;
        if (pos_q == '0) begin
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
          state_d = ST_DONE;
        end else begin
          state_d = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        we = 1'b1;
        if (cmp_res.move) begin
          // parent moves down into the hole
          wdata   = rdata_a;
          pos_d   = parent;
          state_d = ST_UP_RD;
        end else begin
          count_d = count_q + CNT_W'(1);
          state_d = ST_DONE;
        end
      end

      ST_POP_LD: begin
        cur_d   = rdata_a;
        pos_d   = '0;
        count_d = last;
        state_d = (last == '0) ? ST_DONE : ST_DN_RD;
      end

      ST_DN_RD: begin
        raddr_a = left_w[ADDR_W-1:0];
        raddr_b = right_w[ADDR_W-1:0];
        if (!vld_a) begin
          // leaf reached
          we      = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_DN_CMP;
        end
      end

      ST_DN_CMP: begin
        we = 1'b1;
        if (cmp_res.move) begin
          // smaller child moves up into the hole
          wdata   = cmp_res.pick_b ? rdata_b : rdata_a;
          pos_d   = cmp_res.pick_b ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
          state_d = ST_DN_RD;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result beat
  assign busy               = state_q != ST_IDLE;
  assign done_o             = state_q == ST_DONE;
  assign res_o.accepted     = acc_q;
  assign res_o.popped_id    = popped_q;
  assign res_o.top_valid    = count_q != '0;
  assign res_o.top_id       = (count_q != '0) ? root_q : '0;
  assign res_o.entry_count  = count_q;
  assign res_o.is_empty     = count_q == '0;

  // result lasts exactly one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // accepted request always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  // fill level never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

endmodule

// ===== rtl/hmq_mem.sv =====
// hmq_mem: heap slot storage, one write port and two registered read ports.
// Depends on hmq_pkg for the entry type and address width.
module hmq_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [hmq_pkg::ADDR_W-1:0]   waddr_i,
  input  hmq_pkg::entry_t              wdata_i,
  input  logic [hmq_pkg::ADDR_W-1:0]   raddr_a_i,
  input  logic [hmq_pkg::ADDR_W-1:0]   raddr_b_i,
  output hmq_pkg::entry_t              rdata_a_o,
  output hmq_pkg::entry_t              rdata_b_o
);
  import hmq_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rdata_a_q;
  entry_t rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/hmq_cmp.sv =====
// hmq_cmp: shared priority compare unit, one heap level per use.
// Depends on hmq_pkg for entry, mode and decision types.
module hmq_cmp (
  input  hmq_pkg::cmp_mode_e            mode_i,
  input  logic [hmq_pkg::PRIO_BITS-1:0] cur_prio_i,
  input  hmq_pkg::entry_t               ent_a_i,
  input  logic                          vld_a_i,
  input  hmq_pkg::entry_t               ent_b_i,
  input  logic                          vld_b_i,
  output hmq_pkg::cmp_res_t             res_o
);
  import hmq_pkg::*;

  logic                 sel_a;
  logic                 sel_b;
  logic [PRIO_BITS-1:0] best_prio;

  always_comb begin
    // sift-down: left child first, right only if strictly below the best so far
    sel_a     = vld_a_i && (ent_a_i.prio < cur_prio_i);
    best_prio = sel_a ? ent_a_i.prio : cur_prio_i;
    sel_b     = vld_b_i && (ent_b_i.prio < best_prio);

    unique case (mode_i)
      CMP_UP: begin
        // parent in port a moves down only if strictly larger
        res_o.move   = ent_a_i.prio > cur_prio_i;
        res_o.pick_b = 1'b0;
      end
      CMP_DN: begin
        res_o.move   = sel_a || sel_b;
        res_o.pick_b = sel_b;
      end
      default: begin
        res_o.move   = 1'b0;
        res_o.pick_b = 1'b0;
      end
    endcase
  end

endmodule
